### rtl/psm_pkg.sv
// shared types and constants for the priority signal mode controller
// no dependencies; imported by psm_decide and the core top level
package psm_pkg;

  localparam int TIME_W   = 48;
  localparam int NUM_SW   = 7;
  localparam int GAP_W    = 20;
  localparam int MODE_W   = 3;
  localparam int SRC_W    = 3;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd1;

  localparam logic [GAP_W-1:0] GAP_RESET = 20'd20000;

  // switch indexes (bit positions in the level vector)
  localparam logic [SRC_W-1:0] SW_NORTH   = 3'd0;
  localparam logic [SRC_W-1:0] SW_SOUTH   = 3'd1;
  localparam logic [SRC_W-1:0] SW_EAST    = 3'd2;
  localparam logic [SRC_W-1:0] SW_WEST    = 3'd3;
  localparam logic [SRC_W-1:0] SW_WALK    = 3'd4;
  localparam logic [SRC_W-1:0] SW_SERVICE = 3'd5;
  localparam logic [SRC_W-1:0] SW_EMERG   = 3'd6;

  // modes
  localparam logic [MODE_W-1:0] MODE_ALL_STOP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAINT    = 3'd6;

  typedef logic [NUM_SW-1:0]                 sw_vec_t;
  typedef logic [NUM_SW-1:0][TIME_W-1:0]     stamp_arr_t;

  // outcome of one scan
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              changed;
    logic              rejected;
    logic [SRC_W-1:0]  rej_src;
    logic              update;
    sw_vec_t           stamp_we;
  } decision_t;

endpackage

### rtl/psm_decide.sv
// scan decision logic: edge detect, priority select and rapid-press filter
// depends on psm_pkg; purely combinational, used by the core top level
module psm_decide (
  input  psm_pkg::sw_vec_t              levels,
  input  psm_pkg::sw_vec_t              prev_levels,
  input  psm_pkg::stamp_arr_t           stamps,
  input  logic [psm_pkg::TIME_W-1:0]    now_us,
  input  logic                          filter_en,
  input  logic [psm_pkg::GAP_W-1:0]     min_gap,
  input  logic [psm_pkg::MODE_W-1:0]    cur_mode,
  output psm_pkg::decision_t            dec
);
  import psm_pkg::*;

  sw_vec_t           fresh;
  logic              any;
  logic [SRC_W-1:0]  sel;
  logic [TIME_W-1:0] prev;
  logic [TIME_W:0]   diff;
  logic              too_soon;
  logic              sel_fresh;
  logic              ok;
  logic [MODE_W-1:0] sel_mode;

  assign fresh = levels & ~prev_levels;
  assign any   = |levels;

  // fixed priority: emergency, service, pedestrian, north, south, east, west
  always_comb begin
    if (levels[SW_EMERG]) begin
      sel = SW_EMERG;
    end else if (levels[SW_SERVICE]) begin
      sel = SW_SERVICE;
    end else if (levels[SW_WALK]) begin
      sel = SW_WALK;
    end else if (levels[SW_NORTH]) begin
      sel = SW_NORTH;
    end else if (levels[SW_SOUTH]) begin
      sel = SW_SOUTH;
    end else if (levels[SW_EAST]) begin
      sel = SW_EAST;
    end else begin
      sel = SW_WEST;
    end
  end

  assign prev      = stamps[sel];
  assign sel_fresh = any & fresh[sel];
  assign sel_mode  = sel + MODE_W'(1);

  // gap is positive only when there is no borrow and the difference is nonzero
  assign diff     = {1'b0, now_us} - {1'b0, prev};
  assign too_soon = filter_en && (prev != '0) && !diff[TIME_W] &&
                    (diff[TIME_W-1:0] != '0) &&
                    (diff[TIME_W-1:0] < TIME_W'(min_gap));
  assign ok = !too_soon;

  always_comb begin
    dec          = '0;
    dec.mode     = cur_mode;
    dec.stamp_we = '0;
    if (!any) begin
      dec.mode = MODE_ALL_STOP;
    end else if (!sel_fresh) begin
      dec.mode = sel_mode;
    end else begin
      dec.stamp_we[sel] = 1'b1;
      if (ok) begin
        dec.mode   = sel_mode;
        dec.update = (sel == SW_SERVICE);
      end else begin
        dec.rejected = 1'b1;
        dec.rej_src  = sel;
      end
    end
    dec.changed = (dec.mode != cur_mode);
  end

endmodule

### rtl/priority_signal_mode_controller_core.sv
// top level of the priority signal mode controller: handshakes, config and state
// depends on psm_pkg and psm_decide
// an accepted item enters the input register, then moves to the result register when there is room
// throughput: one item per cycle while out_ready holds, set by the single decide stage between the registers
// the decide stage also updates mode, switch levels and press stamps as the item advances
// reset (rst_n low, synchronous): mode all red, levels and stamps zero, filter off,
// min gap 20000 us, both pipeline registers empty
module priority_signal_mode_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psm_pkg::GAP_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_north_req,
  input  logic                          in_south_req,
  input  logic                          in_east_req,
  input  logic                          in_west_req,
  input  logic                          in_walk_req,
  input  logic                          in_service_req,
  input  logic                          in_emergency_req,
  input  logic [psm_pkg::TIME_W-1:0]    in_now_us,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psm_pkg::MODE_W-1:0]    out_mode,
  output logic                          out_mode_changed,
  output logic                          out_press_rejected,
  output logic [psm_pkg::SRC_W-1:0]     out_rejected_source,
  output logic                          out_update_request
);
  import psm_pkg::*;

  // configuration registers
  logic              filter_en_r;
  logic [GAP_W-1:0]  min_gap_r;

  // architectural state
  logic [MODE_W-1:0] mode_r;
  sw_vec_t           prev_levels_r;
  stamp_arr_t        stamps_r;

  // input register
  logic              in_vld_r;
  sw_vec_t           levels_r;
  logic [TIME_W-1:0] now_r;

  // result register
  logic              out_vld_r;
  decision_t         res_r;

  decision_t         dec;
  logic              advance;
  logic              in_take;

  // item moves from the input register to the result register when there is room
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      min_gap_r   <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_EN: filter_en_r <= cfg_wdata[0];
        REG_MIN_GAP:   min_gap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      levels_r <= {in_emergency_req, in_service_req, in_walk_req, in_west_req,
                   in_east_req, in_south_req, in_north_req};
      now_r    <= in_now_us;
    end
  end

  psm_decide u_decide (
    .levels      (levels_r),
    .prev_levels (prev_levels_r),
    .stamps      (stamps_r),
    .now_us      (now_r),
    .filter_en   (filter_en_r),
    .min_gap     (min_gap_r),
    .cur_mode    (mode_r),
    .dec         (dec)
  );

  // state commits as the item advances, so the next item sees the updated state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ALL_STOP;
      prev_levels_r <= '0;
      stamps_r      <= '0;
    end else if (advance) begin
      mode_r        <= dec.mode;
      prev_levels_r <= levels_r;
      for (int i = 0; i < NUM_SW; i++) begin
        if (dec.stamp_we[i]) begin
          stamps_r[i] <= now_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= dec;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_mode            = res_r.mode;
  assign out_mode_changed    = res_r.changed;
  assign out_press_rejected  = res_r.rejected;
  assign out_rejected_source = res_r.rej_src;
  assign out_update_request  = res_r.update;

`ifndef ASSERT_OFF
  // a rejected press never changes the mode
  a_reject_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.rejected) |-> !res_r.changed)
    else $error("rejected press changed the mode");

  // an update request only comes with service mode
  a_update_service: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.update) |-> (res_r.mode == MODE_MAINT && !res_r.rejected))
    else $error("update request outside service mode");

  // shown mode matches the committed mode register
  a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (res_r.mode == mode_r))
    else $error("result mode differs from mode register");

  // at most one press stamp written per item
  a_one_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> $onehot0(dec.stamp_we))
    else $error("more than one stamp written");
`endif

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for priority_signal_mode_controller_core
// needs rtl/psm_pkg.sv and the core rtl; a built-in predictor supplies the expected reports
// driver and monitor are clocked always blocks with random idle gaps and stalls
`timescale 1ns / 100ps

module tb_top;
  import psm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 250;

  // one switch scan: level bit i belongs to switch index i
  typedef struct {
    sw_vec_t           lv;
    logic [TIME_W-1:0] now;
  } switch_scan_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic              changed;
    logic              rejected;
    logic [SRC_W-1:0]  src;
    logic              update;
  } mode_report_t;

  // switches from highest to lowest priority, rank 0 in the low bits
  localparam logic [NUM_SW-1:0][SRC_W-1:0] PRIO_RANK =
    {SW_WEST, SW_EAST, SW_SOUTH, SW_NORTH, SW_WALK, SW_SERVICE, SW_EMERG};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FILTER_EN;
  logic [GAP_W-1:0]     cfg_wdata = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_north_req = 1'b0;
  logic              in_south_req = 1'b0;
  logic              in_east_req = 1'b0;
  logic              in_west_req = 1'b0;
  logic              in_walk_req = 1'b0;
  logic              in_service_req = 1'b0;
  logic              in_emergency_req = 1'b0;
  logic [TIME_W-1:0] in_now_us = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MODE_W-1:0] out_mode;
  logic              out_mode_changed;
  logic              out_press_rejected;
  logic [SRC_W-1:0]  out_rejected_source;
  logic              out_update_request;

  priority_signal_mode_controller_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_north_req        (in_north_req),
    .in_south_req        (in_south_req),
    .in_east_req         (in_east_req),
    .in_west_req         (in_west_req),
    .in_walk_req         (in_walk_req),
    .in_service_req      (in_service_req),
    .in_emergency_req    (in_emergency_req),
    .in_now_us           (in_now_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mode            (out_mode),
    .out_mode_changed    (out_mode_changed),
    .out_press_rejected  (out_press_rejected),
    .out_rejected_source (out_rejected_source),
    .out_update_request  (out_update_request)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mirrors the block's registers, starts at reset values
  // ---------------------------------------------------------------------------
  logic              filt_on_q  = 1'b0;
  logic [GAP_W-1:0]  min_gap_q  = GAP_RESET;
  logic [MODE_W-1:0] mode_q     = MODE_ALL_STOP;
  sw_vec_t           last_lv_q  = '0;
  stamp_arr_t        stamp_q    = '0;

  switch_scan_t scan_backlog[$];
  mode_report_t report_fifo[$];

  int mismatch_cnt  = 0;
  int scans_sent    = 0;
  int reports_seen  = 0;
  int settings_used = 0;
  int cycle_cnt     = 0;

  // one scan through the mode logic; updates the mirrored state
  function automatic mode_report_t predict_mode_report(input switch_scan_t sc);
    mode_report_t      rep;
    sw_vec_t           fresh;
    logic [MODE_W-1:0] prev_mode;
    logic [MODE_W-1:0] next_mode;
    logic [TIME_W-1:0] prior;
    logic [SRC_W-1:0]  sw;
    logic              found;
    rep       = '{default: '0};
    fresh     = sc.lv & ~last_lv_q;
    last_lv_q = sc.lv;       // every level is kept, selected or not
    prev_mode = mode_q;
    next_mode = MODE_ALL_STOP; // nothing held gives all red
    found     = 1'b0;
    for (int k = 0; k < NUM_SW; k++) begin
      sw = PRIO_RANK[k];
      if (!found && sc.lv[sw]) begin
        found = 1'b1;
        if (fresh[sw]) begin
          // new press: stamp first, then the anti-tamper filter
          prior       = stamp_q[sw];
          stamp_q[sw] = sc.now;
          if (filt_on_q && prior != '0 && sc.now > prior &&
              (sc.now - prior) < {{(TIME_W-GAP_W){1'b0}}, min_gap_q}) begin
            rep.rejected = 1'b1;
            rep.src      = sw;
            next_mode    = prev_mode;
          end else begin
            next_mode  = MODE_W'(sw + 1); // mode code is switch index plus one
            rep.update = (sw == SW_SERVICE);
          end
        end else begin
          next_mode = MODE_W'(sw + 1);
        end
      end
    end
    mode_q      = next_mode;
    rep.mode    = next_mode;
    rep.changed = (next_mode != prev_mode);
    return rep;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string fld, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatch_cnt < 10)
        $display("mismatch at report %0d, %s: expected %0d, actual %0d",
                 reports_seen, fld, want, got);
      mismatch_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds the scan backlog, random gaps after each item
  // ---------------------------------------------------------------------------
  switch_scan_t cur_scan;
  int           in_idle_left = 0;
  bit           in_steady    = 1'b0;

  always @(posedge clk) begin : scan_driver
    switch_scan_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        report_fifo.push_back(predict_mode_report(cur_scan));
        scans_sent++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (in_idle_left > 0) begin
          in_idle_left--;
          in_valid <= 1'b0;
        end else if (scan_backlog.size() > 0) begin
          nxt              = scan_backlog.pop_front();
          cur_scan         = nxt;
          in_north_req     <= nxt.lv[SW_NORTH];
          in_south_req     <= nxt.lv[SW_SOUTH];
          in_east_req      <= nxt.lv[SW_EAST];
          in_west_req      <= nxt.lv[SW_WEST];
          in_walk_req      <= nxt.lv[SW_WALK];
          in_service_req   <= nxt.lv[SW_SERVICE];
          in_emergency_req <= nxt.lv[SW_EMERG];
          in_now_us        <= nxt.now;
          in_valid         <= 1'b1;
          // switch between gappy and back-to-back stretches now and then
          if ($urandom_range(0, 49) == 0) in_steady = ~in_steady;
          in_idle_left = in_steady ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each report with the oldest prediction
  // ---------------------------------------------------------------------------
  int out_stall_left = 0;
  bit out_steady     = 1'b0;

  always @(posedge clk) begin : report_monitor
    mode_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_fifo.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected report: mode %0d changed %0d rejected %0d src %0d upd %0d",
                     out_mode, out_mode_changed, out_press_rejected,
                     out_rejected_source, out_update_request);
          mismatch_cnt++;
        end else begin
          want = report_fifo.pop_front();
          check_field("mode", want.mode, out_mode);
          check_field("mode_changed", want.changed, out_mode_changed);
          check_field("press_rejected", want.rejected, out_press_rejected);
          check_field("rejected_source", want.src, out_rejected_source);
          check_field("update_request", want.update, out_update_request);
        end
        reports_seen++;
      end
      if ($urandom_range(0, 63) == 0) out_steady = ~out_steady;
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_steady && $urandom_range(0, 3) == 0) out_stall_left = idle_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycle_cnt,
               report_fifo.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_scan(input sw_vec_t lv, input logic [TIME_W-1:0] now);
    switch_scan_t sc;
    sc.lv  = lv;
    sc.now = now;
    scan_backlog.push_back(sc);
  endtask

  // only while idle; the predictor copy changes with the block's register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAP_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FILTER_EN) filt_on_q = val[0];
    else if (idx == REG_MIN_GAP) min_gap_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every scan is taken and every report is back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    while (scan_backlog.size() != 0 || in_valid || report_fifo.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // running switch levels and clock for the random part
  sw_vec_t           run_lv = '0;
  logic [TIME_W-1:0] run_now = 48'd1;

  // mostly evolving switch patterns with a clock that steps near the threshold,
  // so repeated presses straddle the filter; the rest is noise and time jumps
  task automatic queue_random(input int n, input logic [GAP_W-1:0] gap);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) run_lv = run_lv ^ sw_vec_t'($urandom & $urandom);
      else if (r < 80) run_lv = '0;
      else run_lv = sw_vec_t'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70) run_now = run_now + TIME_W'($urandom_range(0, 2 * int'(gap) + 3));
      else if (r < 78) run_now = run_now - TIME_W'($urandom_range(0, int'(gap) + 1));
      else if (r < 84) run_now = run_now;           // same time again
      else if (r < 90) run_now = TIME_W'({$urandom, $urandom});
      else if (r < 93) run_now = '0;
      else run_now = ~run_now;
      push_scan(run_lv, run_now);
    end
  endtask

  task automatic run_phase(input logic fen, input logic [GAP_W-1:0] gap, input int n);
    write_reg(REG_FILTER_EN, {{(GAP_W-1){1'b0}}, fen});
    write_reg(REG_MIN_GAP, gap);
    settings_used++;
    queue_random(n, gap);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed scans with the reset threshold and the filter switched on
    write_reg(REG_FILTER_EN, {{(GAP_W-1){1'b0}}, 1'b1});
    settings_used++;
    push_scan(7'b0000000, 48'd0);          // nothing held, all red
    push_scan(7'b0000001, 48'd0);          // north pressed at time zero
    push_scan(7'b0000000, 48'd5);
    push_scan(7'b0000001, 48'd10);         // zero stamp still reads as never pressed
    push_scan(7'b0000000, 48'd20);
    push_scan(7'b0000001, 48'd30);         // rapid repeat, rejected
    push_scan(7'b0000001, 48'd40);         // still held, sets mode directly
    push_scan(7'b1111111, 48'd50);         // everything held, emergency wins
    push_scan(7'b0000000, 48'd60);
    push_scan(7'b0100000, 48'd70);         // first service press, update pulse
    push_scan(7'b0000000, 48'd80);
    push_scan(7'b0100000, 48'd30080);      // gap above threshold
    push_scan(7'b0000000, 48'd30090);
    push_scan(7'b0100000, 48'd30080);      // same time as last stamp, accepted
    push_scan(7'b0000000, 48'd30090);
    push_scan(7'b0100000, 48'd100);        // time went backwards, accepted
    push_scan(7'b0000000, 48'd110);
    push_scan(7'b0100000, 48'd150);        // service rejected, no update
    push_scan(7'b0010000, 48'hFFFF_FFFF_FFFF); // walk press at max time
    push_scan(7'b0010010, 48'hFFFF_FFFF_FFFF); // lower south press under held walk
    push_scan(7'b0000110, 48'h8000_0000_0000); // south held beats east press
    push_scan(7'b0001000, 48'h0000_0000_0001); // west press
    push_scan(7'b1000000, 48'd1000);       // emergency repeat inside the gap, rejected
    push_scan(7'b1000001, 48'd1001);       // emergency held over north press
    push_scan(7'b0000000, 48'h5555_5555_5555);
    push_scan(7'b0000100, 48'hAAAA_AAAA_AAAA);
    wait_idle();

    // random phases across filter settings, extremes included
    run_phase(1'b1, GAP_RESET, PHASE_ITEMS);
    run_phase(1'b1, '0, PHASE_ITEMS);
    run_phase(1'b1, '1, PHASE_ITEMS);               // all ones, the largest gap the register holds
    run_phase(1'b1, GAP_W'(1000000), PHASE_ITEMS);
    run_phase(1'b0, GAP_W'(64), PHASE_ITEMS);
    run_phase(1'b1, GAP_W'($urandom_range(1, 5000)), PHASE_ITEMS);

    repeat (8) @(posedge clk);
    if (report_fifo.size() != 0) begin
      $display("%0d predicted reports never arrived", report_fifo.size());
      mismatch_cnt += report_fifo.size();
    end

    $display("covered %0d switch scans under %0d filter settings, %0d reports compared",
             scans_sent, settings_used, reports_seen);
    $display("%0d mismatches in total", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
